// ===== design/ftr_pkg.sv =====
// Shared types and constants of the ID-tagged frame receiver.
// No dependencies; the front, queue, back and top files import this package.
`timescale 1ns / 1ps

package ftr_pkg;

    localparam int FRAME_BYTES_DEF = 32;
    // Enough bits for any frame position up to the largest frame size (64)
    localparam int POS_BITS = 6;

    localparam logic [7:0] DOLLAR     = 8'h24;
    localparam logic [7:0] NEWLINE    = 8'h0A;
    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] DIGIT_NINE = 8'h39;

    typedef logic [POS_BITS-1:0] t_pos;

    typedef enum logic [1:0] {
        FS_ID,
        FS_DOLLAR,
        FS_BODY
    } t_front_state;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_READ,
        BS_SEND
    } t_back_state;

    // One completed frame waiting for readout
    typedef struct packed {
        logic       bank;
        logic [3:0] slot;
        logic       trunc;
        t_pos       last_pos;
    } t_frame_desc;

    // Payload write into the frame store
    typedef struct packed {
        logic       en;
        logic       bank;
        t_pos       pos;
        logic [7:0] data;
    } t_mem_wr;

    // Back end is done with a bank
    typedef struct packed {
        logic en;
        logic bank;
    } t_bank_release;

endpackage

// ===== design/ftr_if.sv =====
// Handshake channels of the frame receiver: received bytes in, frame bytes out.
// Depends on nothing.
`timescale 1ns / 1ps

interface ftr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ftr_frame_if;
    logic       valid;
    logic       ready;
    logic [3:0] slot;
    logic [7:0] frame_byte;
    logic [4:0] byte_index;
    logic       truncated;
    logic       last;

    modport source (output valid, output slot, output frame_byte, output byte_index,
                    output truncated, output last, input ready);
    modport sink   (input valid, input slot, input frame_byte, input byte_index,
                    input truncated, input last, output ready);
endinterface

// ===== design/ftr_front.sv =====
// Front end: parses received bytes, writes payload into a frame store bank
// and hands completed digit-ID frames to the queue. Uses ftr_pkg, ftr_if.
`timescale 1ns / 1ps

module ftr_front
    import ftr_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ftr_rx_if.sink        i_rx,
    input  logic          i_q_full,
    input  t_bank_release i_release,
    output logic          o_push,
    output t_frame_desc   o_push_desc,
    output t_mem_wr       o_wr
);

    localparam t_pos LAST_POS = POS_BITS'(FRAME_BYTES - 1);
    localparam t_pos FIRST_PAYLOAD = POS_BITS'(2);

    t_front_state r_state, n_state;
    logic [7:0]   r_sender_id, n_sender_id;
    t_pos         r_wpos, n_wpos;
    logic         r_ovf, n_ovf;
    logic         r_wbank, n_wbank;
    logic [1:0]   r_busy, n_busy;

    logic       accept;
    logic [7:0] b;
    logic       id_is_digit;

    assign i_rx.ready  = !r_busy[r_wbank] && !i_q_full;
    assign accept      = i_rx.valid && i_rx.ready;
    assign b           = i_rx.rx_byte;
    assign id_is_digit = (r_sender_id >= DIGIT_ZERO) && (r_sender_id <= DIGIT_NINE);

    always_comb begin
        n_state = r_state;
        if (accept) begin
            case (r_state)
                FS_ID:     n_state = FS_DOLLAR;
                FS_DOLLAR: n_state = (b == DOLLAR) ? FS_BODY : FS_ID;
                FS_BODY:   n_state = (b == NEWLINE) ? FS_ID : FS_BODY;
                default:   n_state = FS_ID;
            endcase
        end
    end

    always_comb begin
        n_sender_id = r_sender_id;
        n_wpos      = r_wpos;
        n_ovf       = r_ovf;
        n_wbank     = r_wbank;
        o_push      = 1'b0;
        o_wr.en     = 1'b0;
        o_wr.bank   = r_wbank;
        o_wr.pos    = r_wpos;
        o_wr.data   = b;
        if (accept) begin
            case (r_state)
                FS_ID: begin
                    n_sender_id = b;
                end
                FS_DOLLAR: begin
                    if (b == DOLLAR) begin
                        n_wpos = FIRST_PAYLOAD;
                        n_ovf  = 1'b0;
                    end
                end
                FS_BODY: begin
                    if (b == DOLLAR) begin
                        // restart the frame under the same ID
                        n_wpos = FIRST_PAYLOAD;
                        n_ovf  = 1'b0;
                    end else if (b != NEWLINE) begin
                        // last position stays reserved for the newline
                        if (r_wpos < LAST_POS) begin
                            o_wr.en = 1'b1;
                            n_wpos  = r_wpos + 1'b1;
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else if (id_is_digit) begin
                        o_push  = 1'b1;
                        n_wbank = ~r_wbank;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_push_desc.bank     = r_wbank;
    assign o_push_desc.slot     = 4'(r_sender_id - DIGIT_ZERO);
    assign o_push_desc.trunc    = r_ovf;
    assign o_push_desc.last_pos = r_wpos;

    always_comb begin
        n_busy = r_busy;
        if (i_release.en) begin
            n_busy[i_release.bank] = 1'b0;
        end
        if (o_push) begin
            n_busy[r_wbank] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= FS_ID;
            r_sender_id <= '0;
            r_ovf       <= 1'b0;
            r_wbank     <= 1'b0;
            r_busy      <= '0;
        end else begin
            r_state     <= n_state;
            r_sender_id <= n_sender_id;
            r_ovf       <= n_ovf;
            r_wbank     <= n_wbank;
            r_busy      <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wpos <= n_wpos;
    end

endmodule

// ===== design/ftr_queue.sv =====
// Two-entry queue of completed frame descriptors between front and back end.
// Uses ftr_pkg.
`timescale 1ns / 1ps

module ftr_queue
    import ftr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_frame_desc i_desc,
    input  logic        i_pop,
    output t_frame_desc o_desc,
    output logic        o_full,
    output logic        o_empty
);

    t_frame_desc r_entry [2];
    logic        r_wr_ptr, r_rd_ptr;
    logic [1:0]  r_count;
    logic        do_push, do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_desc  = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== design/ftr_back.sv =====
// Back end: holds the two-bank frame store and reads one completed frame
// out byte by byte onto the output channel. Uses ftr_pkg, ftr_if.
`timescale 1ns / 1ps

module ftr_back
    import ftr_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_mem_wr       i_wr,
    input  t_frame_desc   i_desc,
    input  logic          i_q_empty,
    output logic          o_pop,
    output t_bank_release o_release,
    ftr_frame_if.source   o_frame
);

    localparam int PW = $clog2(FRAME_BYTES);
    localparam int ADDR_BITS = PW + 1;

    logic [7:0]  r_store [2**ADDR_BITS];
    logic [7:0]  r_rd_data;

    t_back_state r_state, n_state;
    t_frame_desc r_desc;
    t_pos        r_idx;

    logic                 rd_en;
    logic [ADDR_BITS-1:0] rd_addr;
    logic                 is_last;
    logic                 sent;

    assign is_last = (r_idx == r_desc.last_pos);
    assign sent    = o_frame.valid && o_frame.ready;
    assign rd_addr = {r_desc.bank, r_idx[PW-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_store[{i_wr.bank, i_wr.pos[PW-1:0]}] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_store[rd_addr];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE: if (!i_q_empty) n_state = BS_READ;
            BS_READ: n_state = BS_SEND;
            BS_SEND: begin
                if (o_frame.ready) begin
                    n_state = is_last ? BS_IDLE : BS_READ;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    always_comb begin
        o_pop          = (r_state == BS_IDLE) && !i_q_empty;
        rd_en          = (r_state == BS_READ);
        o_frame.valid  = (r_state == BS_SEND);
        o_release.en   = (r_state == BS_SEND) && o_frame.ready && is_last;
        o_release.bank = r_desc.bank;
    end

    // ID byte comes from the descriptor, '$' is a constant, the newline from the end mark
    always_comb begin
        if (r_idx == t_pos'(0)) begin
            o_frame.frame_byte = DIGIT_ZERO + {4'b0000, r_desc.slot};
        end else if (r_idx == t_pos'(1)) begin
            o_frame.frame_byte = DOLLAR;
        end else if (is_last) begin
            o_frame.frame_byte = NEWLINE;
        end else begin
            o_frame.frame_byte = r_rd_data;
        end
    end

    assign o_frame.slot       = r_desc.slot;
    assign o_frame.byte_index = 5'(r_idx);
    assign o_frame.truncated  = r_desc.trunc;
    assign o_frame.last       = is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_desc <= i_desc;
            r_idx  <= '0;
        end else if (sent && !is_last) begin
            r_idx <= r_idx + 1'b1;
        end
    end

endmodule

// ===== design/id_tagged_frame_receiver_unit.sv =====
// Receiver of ID-tagged serial frames: front parser, descriptor queue, readout.
// Uses ftr_pkg, ftr_if, ftr_front, ftr_queue, ftr_back.
//
// i_rx carries one received byte per transfer. A byte is the sender ID, then
// '$' opens the frame, payload follows, 0x0A closes it. Frames whose ID is a
// digit leave on o_frame one byte per transfer: ID, '$', payload, newline,
// each tagged with slot, byte_index, truncated and last.
// Throughput: i_rx takes one byte per cycle while i_rx.ready is high. o_frame
// cannot give bytes back to back: a frame store read precedes each output byte.
// Readout start: after the newline transfer the first byte of a frame waits for
// the queue push, then the queue pop and the store read if the readout side is free.
// The frame store has two banks: a new frame fills one bank while the
// other is read out. If both banks hold frames that are not yet fully
// read, i_rx.ready drops until the readout of one of them ends, so a
// stalled o_frame holds back the input once two frames are waiting.
// Reset (i_rst_n low, synchronous) returns the parser to expecting an ID
// and empties the queue; nothing needs to be cleared in the store.
`timescale 1ns / 1ps

module id_tagged_frame_receiver_unit
    import ftr_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ftr_rx_if.sink      i_rx,
    ftr_frame_if.source o_frame
);

    logic          push, pop, q_full, q_empty;
    t_frame_desc   push_desc, pop_desc;
    t_mem_wr       wr;
    t_bank_release release_bank;

    ftr_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx        (i_rx),
        .i_q_full    (q_full),
        .i_release   (release_bank),
        .o_push      (push),
        .o_push_desc (push_desc),
        .o_wr        (wr)
    );

    ftr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .i_pop   (pop),
        .o_desc  (pop_desc),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    ftr_back #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr),
        .i_desc    (pop_desc),
        .i_q_empty (q_empty),
        .o_pop     (pop),
        .o_release (release_bank),
        .o_frame   (o_frame)
    );

endmodule
